// ===== sv/pdpb_pkg.sv =====
`timescale 1ns / 1ps
package pdpb_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] CMD_ENQ  = 3'd0;
  localparam logic [2:0] CMD_DEQ  = 3'd1;
  localparam logic [2:0] CMD_DROP = 3'd2;
  localparam logic [2:0] CMD_FIND = 3'd3;
  localparam logic [2:0] CMD_SIZE = 3'd4;
  localparam logic [2:0] CMD_TICK = 3'd5;

  localparam logic [1:0] CFG_MAX_ENTRIES = 2'd0;
  localparam logic [1:0] CFG_MAX_PER     = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

  localparam logic [6:0]  RST_MAX_ENTRIES = 7'd64;
  localparam logic [6:0]  RST_MAX_PER     = 7'd5;
  localparam logic [30:0] RST_TIMEOUT     = 31'd30000;

  typedef struct packed {
    logic [63:0] pid;
    logic [31:0] dest;
    logic [31:0] deadline;
  } entry_t;

endpackage

// ===== sv/pdpb_ram.sv =====
`timescale 1ns / 1ps
module pdpb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== sv/per_destination_packet_buffer_unit.sv =====
`timescale 1ns / 1ps
// Channel   | Ports                                          | Transfer
// ----------+------------------------------------------------+---------------------------
// command   | cmd_i, dest_addr_i, packet_id_i                | start_i & !busy_o
// result    | ok_o, out_packet_id_o, out_dest_addr_o,        | done_o, one cycle, no stall
//           | entry_count_o, purged_count_o                  |
// config    | cfg_idx_i, cfg_data_i                          | cfg_we_i
// Enqueue, dequeue and drop take two slot scans (purge, then main) through the
// single-port-read slot RAM; find and size take one scan; tick and unknown commands
// answer from idle without raising busy_o. Otherwise busy_o stays high from transfer
// until the result strobe; done_o is a one-cycle pulse.
// Reset clears occupancy, time and state and loads the default limits; slot contents are never cleared.
module per_destination_packet_buffer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  cmd_i,
  input  logic [31:0] dest_addr_i,
  input  logic [63:0] packet_id_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  output logic        done_o,
  output logic        ok_o,
  output logic [63:0] out_packet_id_o,
  output logic [31:0] out_dest_addr_o,
  output logic [6:0]  entry_count_o,
  output logic [6:0]  purged_count_o
);
  import pdpb_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_PURGE, ST_MAIN} state_e;

  state_e      state_q;
  logic [2:0]  cmd_q;
  logic [31:0] dest_q;
  logic [63:0] pid_q;
  logic [6:0]  max_entries_q, max_per_q;
  logic [30:0] timeout_q;
  logic [31:0] now_q;
  logic [CW-1:0] occ_q, issue_q, pidx_q, keep_q, per_q;
  logic        pend_q, dup_q, found_q;
  logic [CW-1:0] purged_q;

  logic        done_q, ok_q;
  logic [63:0] opid_q;
  logic [31:0] odest_q;
  logic [6:0]  ocount_q, opurged_q;

  entry_t      rdata;
  entry_t      wdata;
  logic        we, re, gone, match, scan_end, enq_ok;
  logic [AW-1:0] waddr;
  logic [CW-1:0] cap;

  assign match    = rdata.dest == dest_q;
  assign re       = (state_q != ST_IDLE) && (issue_q < occ_q);
  assign scan_end = (state_q != ST_IDLE) && !(issue_q < occ_q) && !pend_q;
  assign cap      = (32'(max_entries_q) < 32'(QUEUE_DEPTH)) ? CW'(max_entries_q)
                                                            : CW'(QUEUE_DEPTH);
  assign enq_ok   = !dup_q && (32'(per_q) < 32'(max_per_q)) && (occ_q < cap);

  always_comb begin
    gone = 1'b0;
    if (state_q == ST_PURGE) begin
      gone = (rdata.deadline - now_q) >= 32'h8000_0000;
    end else begin
      unique case (cmd_q)
        CMD_DEQ:  gone = match && !found_q;
        CMD_DROP: gone = match;
        default:  gone = 1'b0;
      endcase
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = keep_q[AW-1:0];
    wdata = rdata;
    if (pend_q) begin
      we = !gone && (keep_q != pidx_q);
    end else if (scan_end && state_q == ST_MAIN && cmd_q == CMD_ENQ && enq_ok) begin
      we             = 1'b1;
      waddr          = occ_q[AW-1:0];
      wdata.pid      = pid_q;
      wdata.dest     = dest_q;
      wdata.deadline = now_q + {1'b0, timeout_q};
    end
  end

  pdpb_ram #(
    .Width($bits(entry_t)),
    .Depth(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(issue_q[AW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      max_entries_q <= RST_MAX_ENTRIES;
      max_per_q     <= RST_MAX_PER;
      timeout_q     <= RST_TIMEOUT;
      now_q         <= '0;
      occ_q         <= '0;
      issue_q       <= '0;
      pidx_q        <= '0;
      keep_q        <= '0;
      per_q         <= '0;
      purged_q      <= '0;
      pend_q        <= 1'b0;
      dup_q         <= 1'b0;
      found_q       <= 1'b0;
      done_q        <= 1'b0;
      ok_q          <= 1'b0;
      opid_q        <= '0;
      odest_q       <= '0;
      ocount_q      <= '0;
      opurged_q     <= '0;
      cmd_q         <= '0;
      dest_q        <= '0;
      pid_q         <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_ENTRIES: max_entries_q <= cfg_data_i[6:0];
          CFG_MAX_PER:     max_per_q     <= cfg_data_i[6:0];
          CFG_TIMEOUT:     timeout_q     <= cfg_data_i;
          default: ;
        endcase
      end

      if (re) begin
        issue_q <= issue_q + 1'b1;
        pidx_q  <= issue_q;
      end
      pend_q <= re;

      if (pend_q) begin
        if (!gone) begin
          keep_q <= keep_q + 1'b1;
        end
        if (state_q == ST_MAIN && match) begin
          if (!found_q && cmd_q == CMD_DEQ) begin
            opid_q  <= rdata.pid;
            odest_q <= rdata.dest;
          end
          found_q <= 1'b1;
          per_q   <= per_q + 1'b1;
          if (rdata.pid == pid_q) begin
            dup_q <= 1'b1;
          end
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            cmd_q   <= cmd_i;
            dest_q  <= dest_addr_i;
            pid_q   <= packet_id_i;
            issue_q <= '0;
            keep_q  <= '0;
            per_q   <= '0;
            dup_q   <= 1'b0;
            found_q <= 1'b0;
            opid_q  <= '0;
            odest_q <= '0;
            purged_q <= '0;
            priority case (cmd_i)
              CMD_ENQ, CMD_DEQ, CMD_DROP, CMD_SIZE: state_q <= ST_PURGE;
              CMD_FIND: state_q <= ST_MAIN;
              CMD_TICK: begin
                now_q     <= now_q + 1'b1;
                done_q    <= 1'b1;
                ok_q      <= 1'b1;
                ocount_q  <= 7'(occ_q);
                opurged_q <= '0;
              end
              default: begin
                done_q    <= 1'b1;
                ok_q      <= 1'b0;
                ocount_q  <= 7'(occ_q);
                opurged_q <= '0;
              end
            endcase
          end
        end
        ST_PURGE: begin
          if (scan_end) begin
            occ_q    <= keep_q;
            purged_q <= occ_q - keep_q;
            issue_q  <= '0;
            keep_q   <= '0;
            if (cmd_q == CMD_SIZE) begin
              state_q   <= ST_IDLE;
              done_q    <= 1'b1;
              ok_q      <= 1'b1;
              ocount_q  <= 7'(keep_q);
              opurged_q <= 7'(occ_q - keep_q);
            end else begin
              state_q <= ST_MAIN;
            end
          end
        end
        ST_MAIN: begin
          if (scan_end) begin
            state_q   <= ST_IDLE;
            done_q    <= 1'b1;
            opurged_q <= 7'(purged_q);
            priority case (cmd_q)
              CMD_ENQ: begin
                ok_q     <= enq_ok;
                occ_q    <= enq_ok ? occ_q + 1'b1 : occ_q;
                ocount_q <= 7'(enq_ok ? occ_q + 1'b1 : occ_q);
              end
              CMD_DEQ: begin
                ok_q     <= found_q;
                occ_q    <= keep_q;
                ocount_q <= 7'(keep_q);
              end
              CMD_DROP: begin
                ok_q     <= occ_q != keep_q;
                occ_q    <= keep_q;
                ocount_q <= 7'(occ_q - keep_q);
              end
              default: begin
                ok_q      <= found_q;
                ocount_q  <= 7'(occ_q);
              end
            endcase
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o          = state_q != ST_IDLE;
  assign done_o          = done_q;
  assign ok_o            = ok_q;
  assign out_packet_id_o = opid_q;
  assign out_dest_addr_o = odest_q;
  assign entry_count_o   = ocount_q;
  assign purged_count_o  = opurged_q;

endmodule

// ===== test/per_destination_packet_buffer_checker.sv =====
`timescale 1ns / 1ps
module per_destination_packet_buffer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  cmd_i,
  input  logic [31:0] dest_addr_i,
  input  logic [63:0] packet_id_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  input  logic        done_i,
  input  logic        ok_i,
  input  logic [63:0] out_packet_id_i,
  input  logic [31:0] out_dest_addr_i,
  input  logic [6:0]  entry_count_i,
  input  logic [6:0]  purged_count_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o
);
  import pdpb_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [63:0] pid;
    logic [31:0] dest;
    logic [6:0]  count;
    logic [6:0]  purged;
  } buf_result_t;

  entry_t      slots[$];
  logic [31:0] now_q;
  logic [6:0]  lim_total, lim_per;
  logic [30:0] timeout_q;
  buf_result_t expected_q[$];

  function automatic bit stale(entry_t e, logic [31:0] now);
    logic [31:0] left;
    left = e.deadline - now;
    return left[31];
  endfunction

  task automatic predict_buffer(logic [2:0] cmd, logic [31:0] dest, logic [63:0] pid);
    buf_result_t r;
    entry_t      kept[$];
    entry_t      fresh;
    int          per, cap, removed;
    bit          dup;
    r = '0;
    if (cmd inside {CMD_ENQ, CMD_DEQ, CMD_DROP, CMD_SIZE}) begin
      kept = {};
      foreach (slots[k]) if (!stale(slots[k], now_q)) kept = {kept, slots[k]};
      r.purged = 7'(slots.size() - kept.size());
      slots = kept;
    end
    r.count = 7'(slots.size());
    case (cmd)
      CMD_ENQ: begin
        per = 0;
        dup = 0;
        cap = (lim_total < QUEUE_DEPTH) ? int'(lim_total) : QUEUE_DEPTH;
        foreach (slots[k]) if (slots[k].dest == dest) begin
          per++;
          if (slots[k].pid == pid) dup = 1;
        end
        if (!dup && per < lim_per && slots.size() < cap) begin
          fresh.pid = pid;
          fresh.dest = dest;
          fresh.deadline = now_q + {1'b0, timeout_q};
          slots = {slots, fresh};
          r.ok = 1;
        end
        r.count = 7'(slots.size());
      end
      CMD_DEQ: begin
        foreach (slots[k]) if (!r.ok && slots[k].dest == dest) begin
          r.pid = slots[k].pid;
          r.dest = dest;
          r.ok = 1;
          slots.delete(k);
          break;
        end
        r.count = 7'(slots.size());
      end
      CMD_DROP: begin
        kept = {};
        foreach (slots[k]) if (slots[k].dest != dest) kept = {kept, slots[k]};
        removed = slots.size() - kept.size();
        slots = kept;
        r.count = 7'(removed);
        r.ok = removed != 0;
      end
      CMD_FIND: foreach (slots[k]) if (slots[k].dest == dest) r.ok = 1;
      CMD_SIZE: r.ok = 1;
      CMD_TICK: begin
        now_q = now_q + 32'd1;
        r.ok = 1;
      end
      default: ;
    endcase
    expected_q = {expected_q, r};
  endtask

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    buf_result_t got, exp_r;
    if (!rst_ni) begin
      slots = {};
      expected_q = {};
      now_q = '0;
      lim_total = RST_MAX_ENTRIES;
      lim_per = RST_MAX_PER;
      timeout_q = RST_TIMEOUT;
      fail_count_o = 0;
      results_o = 0;
    end else begin
      if (done_i) begin
        got = '{ok_i, out_packet_id_i, out_dest_addr_i, entry_count_i, purged_count_i};
        results_o++;
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"mismatch: exp ok=%b id=%h dst=%h cnt=%0d prg=%0d",
                        " / got ok=%b id=%h dst=%h cnt=%0d prg=%0d"},
                exp_r.ok, exp_r.pid, exp_r.dest, exp_r.count, exp_r.purged,
                got.ok, got.pid, got.dest, got.count, got.purged);
          end
        end
      end
      if (start_i && !busy_i) predict_buffer(cmd_i, dest_addr_i, packet_id_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MAX_ENTRIES) lim_total = cfg_data_i[6:0];
        else if (cfg_idx_i == CFG_MAX_PER) lim_per = cfg_data_i[6:0];
        else if (cfg_idx_i == CFG_TIMEOUT) timeout_q = cfg_data_i;
      end
    end
  end

endmodule

// ===== test/per_destination_packet_buffer_unit_tb.sv =====
`timescale 1ns / 1ps
module per_destination_packet_buffer_unit_tb;
  import pdpb_pkg::*;

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam logic [1:0] CFG_SPARE   = 2'd3;

  logic        clk_i = 0, rst_ni = 0;
  logic        start_i = 0, cfg_we_i = 0;
  logic [2:0]  cmd_i = '0;
  logic [31:0] dest_addr_i = '0;
  logic [63:0] packet_id_i = '0;
  logic [1:0]  cfg_idx_i = '0;
  logic [30:0] cfg_data_i = '0;
  logic        busy_o, done_o, ok_o;
  logic [63:0] out_packet_id_o;
  logic [31:0] out_dest_addr_o;
  logic [6:0]  entry_count_o, purged_count_o;
  int          fail_count, pending, results;
  int          idle_cycles, sent;
  bit          calm;
  logic [31:0] dest_pool[8];
  logic [63:0] id_pool[8];

  always #10 clk_i = ~clk_i;

  per_destination_packet_buffer_unit u_top (.*);

  per_destination_packet_buffer_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .cmd_i, .dest_addr_i, .packet_id_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .done_i(done_o), .ok_i(ok_o),
    .out_packet_id_i(out_packet_id_o), .out_dest_addr_i(out_dest_addr_o),
    .entry_count_i(entry_count_o), .purged_count_i(purged_count_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results)
  );

  always @(posedge clk_i) begin
    if (start_i && !busy_o || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic issue(logic [2:0] cmd, logic [31:0] dest, logic [63:0] pid);
    while (!calm && $urandom_range(99) < 35) begin
      start_i <= 0;
      @(posedge clk_i);
    end
    start_i <= 1;
    cmd_i <= cmd;
    dest_addr_i <= dest;
    packet_id_i <= pid;
    do @(posedge clk_i); while (busy_o);
    sent++;
  endtask

  task automatic drain();
    start_i <= 0;
    while (pending != 0 || busy_o) @(posedge clk_i);
    repeat (140) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] data);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int n, int ntick);
    logic [2:0] c;
    int         pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 40) c = CMD_ENQ;
      else if (pick < 55) c = CMD_DEQ;
      else if (pick < 62) c = CMD_DROP;
      else if (pick < 70) c = CMD_FIND;
      else if (pick < 76) c = CMD_SIZE;
      else if (pick < 76 + ntick) c = CMD_TICK;
      else c = 3'($urandom_range(7));
      issue(c, ($urandom_range(9) == 0) ? 32'($urandom) : dest_pool[$urandom_range(7)],
            ($urandom_range(5) == 0) ? {$urandom, $urandom} : id_pool[$urandom_range(7)]);
    end
  endtask

  initial begin
    sent = 0;
    calm = 0;
    foreach (dest_pool[k]) dest_pool[k] = $urandom;
    foreach (id_pool[k]) id_pool[k] = {$urandom, $urandom};
    dest_pool[0] = '0;
    dest_pool[1] = '1;
    id_pool[0] = '0;
    id_pool[1] = '1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    issue(CMD_DEQ, '0, '0);
    issue(CMD_FIND, '1, '0);
    issue(CMD_ENQ, '0, '0);
    issue(CMD_ENQ, '0, '0);
    issue(CMD_ENQ, '1, '1);
    issue(CMD_ENQ, '0, '1);
    issue(CMD_FIND, '0, '0);
    issue(CMD_SIZE, '0, '0);
    issue(CMD_DEQ, '0, '0);
    issue(CMD_DROP, '1, '0);
    issue(CMD_DROP, '1, '0);
    issue(CMD_SPARE_A, '1, '1);
    issue(CMD_SPARE_B, '0, '0);
    drain();
    write_reg(CFG_TIMEOUT, 31'd2);
    write_reg(CFG_MAX_PER, 31'd2);
    write_reg(CFG_MAX_ENTRIES, 31'd3);
    write_reg(CFG_SPARE, '1);
    issue(CMD_ENQ, 32'd5, 64'd1);
    issue(CMD_ENQ, 32'd5, 64'd2);
    issue(CMD_ENQ, 32'd5, 64'd3);
    issue(CMD_ENQ, 32'd6, 64'd3);
    issue(CMD_ENQ, 32'd7, 64'd3);
    repeat (3) issue(CMD_TICK, '0, '0);
    issue(CMD_FIND, 32'd5, '0);
    issue(CMD_SIZE, '0, '0);
    drain();
    write_reg(CFG_MAX_ENTRIES, '0);
    issue(CMD_ENQ, 32'd9, 64'd9);
    drain();
    write_reg(CFG_MAX_ENTRIES, 31'd127);
    write_reg(CFG_MAX_PER, 31'd64);
    write_reg(CFG_TIMEOUT, 31'h7fffffff);
    random_phase(250, 4);
    drain();
    write_reg(CFG_TIMEOUT, 31'd0);
    write_reg(CFG_MAX_PER, 31'd127);
    random_phase(150, 20);
    drain();
    write_reg(CFG_TIMEOUT, 31'd15);
    write_reg(CFG_MAX_PER, 31'd4);
    write_reg(CFG_MAX_ENTRIES, 31'd20);
    calm = 1;
    random_phase(200, 14);
    calm = 0;
    drain();
    write_reg(CFG_TIMEOUT, 31'($urandom_range(40, 1)));
    write_reg(CFG_MAX_PER, 31'd0);
    random_phase(30, 10);
    drain();
    write_reg(CFG_MAX_PER, 31'd64);
    write_reg(CFG_MAX_ENTRIES, 31'd64);
    write_reg(CFG_TIMEOUT, 31'd60);
    random_phase(300, 10);
    drain();
    $display("covered %0d commands, %0d results, limit and timeout settings at extremes",
             sent, results);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pdpb_pkg.sv
sv/pdpb_ram.sv
sv/per_destination_packet_buffer_unit.sv
test/per_destination_packet_buffer_checker.sv
test/per_destination_packet_buffer_unit_tb.sv
